// File: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg: shared constants for the TLB / page table translator
// Address split and result layout widths.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned OffsetW = 8;
  localparam int unsigned PageW   = 8;
  localparam int unsigned PhysW   = 15;
  localparam int unsigned AgeW    = 64;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // result fields, highest bit first
  typedef struct packed {
    logic [5:0]         pad;
    logic [PageW-1:0]   evicted_page;
    logic               evicted;
    logic               page_fault;
    logic               tlb_hit;
    logic [PhysW-1:0]   physical_address;
  } result_t;

endpackage

// File: rtl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tlb_page_table_lru_translator_core.sv
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator_core: virtual to physical address translator
// FIFO-filled TLB, page table and least-recently-used frame replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries a 16-bit logical address (page 15:8, offset 7:0).
//   Master stream returns one result per address: physical address, TLB hit,
//   page fault, evicted flag and evicted page.
//   One address is in flight at a time; s_axis_tready is high only while
//   the sequencer is idle.
// Steps per address: page reduction modulo PAGES, TLB search, then on a
//   miss the page table; a fault takes a free frame if one is left, else
//   an LRU search picks a victim frame whose mapping is dropped; the final
//   step fills the TLB on a miss, stamps the age and sends the result.
//   The TLB is searched one entry per cycle by a shared comparator, and the
//   LRU search reads one frame age per cycle from the age RAM port.
// Reset clears the TLB valid bits, page valid bits, FIFO head, frame count
// and access clock; RAM contents are only read after they were written.
// A stalled receiver holds the result in the output register; the next
// address is taken and worked on, and only its final step waits.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translator_core #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned FRAMES      = 128,
  parameter int unsigned PAGES       = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: logical_address[15:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tlbpt_pkg::InDataW-1:0]  s_axis_tdata,
  // tdata: physical_address[14:0], tlb_hit[15], page_fault[16],
  //        evicted[17], evicted_page[25:18], zero fill[31:26]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tlbpt_pkg::OutDataW-1:0] m_axis_tdata
);

  import tlbpt_pkg::*;

  localparam int unsigned TW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FCW = $clog2(FRAMES + 1);
  localparam int unsigned PW  = (PAGES > 1) ? $clog2(PAGES) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;  // page modulo PAGES
  localparam logic [2:0] S_TLB   = 3'd2;  // one TLB entry per cycle
  localparam logic [2:0] S_PT    = 3'd3;  // page table result
  localparam logic [2:0] S_SCAN  = 3'd4;  // LRU search over frame ages
  localparam logic [2:0] S_EVICT = 3'd5;  // drop victim mapping
  localparam logic [2:0] S_FIN   = 3'd6;  // TLB fill, age stamp, result

  logic [2:0] state_q, state_d;

  logic [PageW-1:0]   page_q, page_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [FW-1:0]      frame_q, frame_d;
  logic               hit_q, hit_d;
  logic               fault_q, fault_d;
  logic               evicted_q, evicted_d;
  logic [PageW-1:0]   ev_page_q, ev_page_d;
  logic [TW-1:0]      tidx_q, tidx_d;
  logic [FCW-1:0]     cnt_q, cnt_d;
  logic [AgeW-1:0]    best_age_q, best_age_d;
  logic [FW-1:0]      best_idx_q, best_idx_d;

  logic [TW-1:0]      head_q, head_d;
  logic [FCW-1:0]     used_q, used_d;
  logic [AgeW-1:0]    clock_q, clock_d;
  logic [PAGES-1:0]   pvalid_q, pvalid_d;

  logic [TLB_ENTRIES-1:0] tvalid_q, tvalid_d;
  logic [PageW-1:0]       tpage_q  [TLB_ENTRIES];
  logic [FW-1:0]          tframe_q [TLB_ENTRIES];
  logic                   tlb_wr;

  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;

  logic [PW-1:0]          pidx;
  logic                   out_free;

  // RAM ports
  logic              pf_we, pf_re;
  logic [FW-1:0]     pf_rdata;
  logic              own_we, own_re;
  logic [FW-1:0]     own_raddr;
  logic [PageW-1:0]  own_rdata;
  logic              age_we, age_re;
  logic [AgeW-1:0]   age_rdata;

  logic              cand_better;
  logic [FW-1:0]     cand_idx;
  logic [PageW-1:0]  frame8;

  assign pidx     = page_q[PW-1:0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign frame8   = PageW'(frame_q);

  // page -> frame
  tlbpt_ram #(.WIDTH(FW), .DEPTH(PAGES)) u_page_frame (
    .clk_i   (clk_i),
    .we_i    (pf_we),
    .waddr_i (pidx),
    .wdata_i (frame_d),
    .re_i    (pf_re),
    .raddr_i (pidx),
    .rdata_o (pf_rdata)
  );

  // frame -> owning page
  tlbpt_ram #(.WIDTH(PageW), .DEPTH(FRAMES)) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (frame_d),
    .wdata_i (page_q),
    .re_i    (own_re),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  // frame -> last access stamp
  tlbpt_ram #(.WIDTH(AgeW), .DEPTH(FRAMES)) u_frame_age (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (frame_q),
    .wdata_i (clock_q),
    .re_i    (age_re),
    .raddr_i (cnt_q[FW-1:0]),
    .rdata_o (age_rdata)
  );

  // LRU compare: first minimum wins, so only strictly older replaces
  assign cand_idx    = FW'(cnt_q - FCW'(1));
  assign cand_better = (cnt_q == FCW'(1)) || (age_rdata < best_age_q);

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    offset_d    = offset_q;
    frame_d     = frame_q;
    hit_d       = hit_q;
    fault_d     = fault_q;
    evicted_d   = evicted_q;
    ev_page_d   = ev_page_q;
    tidx_d      = tidx_q;
    cnt_d       = cnt_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    head_d      = head_q;
    used_d      = used_q;
    clock_d     = clock_q;
    pvalid_d    = pvalid_q;
    tvalid_d    = tvalid_q;
    tlb_wr      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    pf_we       = 1'b0;
    pf_re       = 1'b0;
    own_we      = 1'b0;
    own_re      = 1'b0;
    own_raddr   = cand_better ? cand_idx : best_idx_q;
    age_we      = 1'b0;
    age_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          page_d    = s_axis_tdata[AddrW-1:OffsetW];
          offset_d  = s_axis_tdata[OffsetW-1:0];
          hit_d     = 1'b0;
          fault_d   = 1'b0;
          evicted_d = 1'b0;
          ev_page_d = '0;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        // repeated subtract; one step at most when PAGES is 256
        if ({1'b0, page_q} >= 9'(PAGES)) begin
          page_d = PageW'({1'b0, page_q} - 9'(PAGES));
        end else begin
          tidx_d  = '0;
          state_d = S_TLB;
        end
      end
      S_TLB: begin
        if (tvalid_q[tidx_q] && tpage_q[tidx_q] == page_q) begin
          hit_d   = 1'b1;
          frame_d = tframe_q[tidx_q];
          state_d = S_FIN;
        end else if (tidx_q == TW'(TLB_ENTRIES - 1)) begin
          pf_re   = 1'b1;
          state_d = S_PT;
        end else begin
          tidx_d = tidx_q + TW'(1);
        end
      end
      S_PT: begin
        if (pvalid_q[pidx]) begin
          frame_d = pf_rdata;
          state_d = S_FIN;
        end else begin
          fault_d = 1'b1;
          if (used_q < FCW'(FRAMES)) begin
            frame_d        = used_q[FW-1:0];
            used_d         = used_q + FCW'(1);
            pf_we          = 1'b1;
            own_we         = 1'b1;
            pvalid_d[pidx] = 1'b1;
            state_d        = S_FIN;
          end else begin
            cnt_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read age cnt, compare age cnt-1 from the previous read
        if (cnt_q < FCW'(FRAMES)) begin
          age_re = 1'b1;
        end
        if (cnt_q != '0 && cand_better) begin
          best_age_d = age_rdata;
          best_idx_d = cand_idx;
        end
        if (cnt_q == FCW'(FRAMES)) begin
          own_re  = 1'b1;
          frame_d = own_raddr;
          state_d = S_EVICT;
        end else begin
          cnt_d = cnt_q + FCW'(1);
        end
      end
      S_EVICT: begin
        // owner was stored already reduced modulo PAGES
        evicted_d = 1'b1;
        ev_page_d = own_rdata;
        pvalid_d[own_rdata[PW-1:0]] = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tvalid_q[i] && tframe_q[i] == frame_q) begin
            tvalid_d[i] = 1'b0;
          end
        end
        pf_we          = 1'b1;
        own_we         = 1'b1;
        pvalid_d[pidx] = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (!hit_q) begin
            tlb_wr           = 1'b1;
            tvalid_d[head_q] = 1'b1;
            head_d = (head_q == TW'(TLB_ENTRIES - 1)) ? '0 : head_q + TW'(1);
          end
          age_we                 = 1'b1;
          clock_d                = clock_q + AgeW'(1);
          out_valid_d            = 1'b1;
          out_d.pad              = '0;
          out_d.physical_address = {frame8[PhysW-OffsetW-1:0], offset_q};
          out_d.tlb_hit          = hit_q;
          out_d.page_fault       = fault_q;
          out_d.evicted          = evicted_q;
          out_d.evicted_page     = ev_page_q;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      used_q      <= '0;
      clock_q     <= '0;
      pvalid_q    <= '0;
      tvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      used_q      <= used_d;
      clock_q     <= clock_d;
      pvalid_q    <= pvalid_d;
      tvalid_q    <= tvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload, no reset
  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    offset_q   <= offset_d;
    frame_q    <= frame_d;
    hit_q      <= hit_d;
    fault_q    <= fault_d;
    evicted_q  <= evicted_d;
    ev_page_q  <= ev_page_d;
    tidx_q     <= tidx_d;
    cnt_q      <= cnt_d;
    best_age_q <= best_age_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
    if (tlb_wr) begin
      tpage_q[head_q]  <= page_q;
      tframe_q[head_q] <= frame_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
